// ----- hdl/obcm_pkg.sv -----
// Shared types and constants for the overlap box cluster merge block.
// No dependencies; imported by the controller, datapath and top level.
package obcm_pkg;

  localparam int SCORE_W = 16;

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic load;      // capture the incoming box
    logic wr_en;     // write a cluster entry
    logic wr_merge;  // write the merged union rather than the new box
    logic emit;      // load the result registers
    logic last;      // result closes the flush
    logic empty;     // flush of an empty table
    logic ovf;       // drop flag as seen by this flush
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic hit;       // box overlaps the cluster being read
  } dp_status_t;

endpackage

// ----- hdl/obcm_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module obcm_ram #(
  parameter int WIDTH = 66,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- hdl/obcm_ctrl.sv -----
// Controller for the cluster merge: state machine, scan index, cluster count
// and drop flag. Depends on obcm_pkg.
module obcm_ctrl #(
  parameter int MAX_CLUSTERS = 16,
  localparam int IDX_W = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic                   opcode,
  output logic                   busy,
  output obcm_pkg::ctrl_cmd_t    cmd,
  input  obcm_pkg::dp_status_t   status,
  output logic [IDX_W-1:0]       rd_addr,
  output logic [IDX_W-1:0]       wr_addr
);
  import obcm_pkg::*;

  localparam int CNT_W = $clog2(MAX_CLUSTERS + 1);

  typedef enum logic [3:0] {
    IDLE   = 4'b0001,
    SCAN   = 4'b0010,
    APPEND = 4'b0100,
    FLUSH  = 4'b1000
  } state_t;

  state_t           state, state_next;
  logic [IDX_W-1:0] idx, idx_next;
  logic [CNT_W-1:0] count, count_next;
  logic             drop_flag, drop_next;
  logic [CNT_W-1:0] idx_ext;
  logic             idx_last;
  logic             has_room;

  assign idx_ext  = CNT_W'(idx);
  assign idx_last = (idx_ext + CNT_W'(1)) == count;
  assign has_room = count < CNT_W'(MAX_CLUSTERS);
  assign busy     = (state != IDLE);
  assign rd_addr  = idx_next;

  always_comb begin
    state_next = state;
    idx_next   = idx;
    count_next = count;
    drop_next  = drop_flag;
    cmd        = '0;
    cmd.ovf    = drop_flag;
    wr_addr    = count[IDX_W-1:0];
    case (state)
      IDLE: begin
        idx_next = '0;
        if (start) begin
          if (opcode == OP_ADD) begin
            cmd.load   = 1'b1;
            state_next = (count == '0) ? APPEND : SCAN;
          end else if (count == '0) begin
            cmd.emit  = 1'b1;
            cmd.empty = 1'b1;
            cmd.last  = 1'b1;
            drop_next = 1'b0;
          end else begin
            state_next = FLUSH;
          end
        end
      end
      SCAN: begin
        if (status.hit) begin
          cmd.wr_en    = 1'b1;
          cmd.wr_merge = 1'b1;
          wr_addr      = idx;
          state_next   = IDLE;
        end else if (idx_last) begin
          // no overlap anywhere: append, or drop when full
          if (has_room) begin
            cmd.wr_en  = 1'b1;
            count_next = count + CNT_W'(1);
          end else begin
            drop_next = 1'b1;
          end
          state_next = IDLE;
        end else begin
          idx_next = idx + IDX_W'(1);
        end
      end
      APPEND: begin
        cmd.wr_en  = 1'b1;
        count_next = count + CNT_W'(1);
        state_next = IDLE;
      end
      FLUSH: begin
        cmd.emit = 1'b1;
        if (idx_last) begin
          cmd.last   = 1'b1;
          count_next = '0;
          drop_next  = 1'b0;
          state_next = IDLE;
        end else begin
          idx_next = idx + IDX_W'(1);
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      idx       <= '0;
      count     <= '0;
      drop_flag <= 1'b0;
    end else begin
      state     <= state_next;
      idx       <= idx_next;
      count     <= count_next;
      drop_flag <= drop_next;
    end
  end

  a_write_ends_item: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_en |=> state == IDLE)
    else $error("cluster write did not end the item");

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && cmd.last) |=> (count == '0 && !drop_flag))
    else $error("flush left clusters or drop flag behind");

  a_drop_when_full: assert property (@(posedge clk) disable iff (rst)
    $rose(drop_flag) |-> count == CNT_W'(MAX_CLUSTERS))
    else $error("box dropped while table had room");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_en && !cmd.wr_merge |-> has_room)
    else $error("append past table end");

endmodule

// ----- hdl/obcm_datapath.sv -----
// Datapath for the cluster merge: box register, cluster RAM, overlap and
// union logic, result registers. Depends on obcm_pkg and obcm_ram.
module obcm_datapath #(
  parameter int MAX_CLUSTERS = 16,
  parameter int COORD_BITS   = 12,
  localparam int IDX_W = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  obcm_pkg::ctrl_cmd_t           cmd,
  output obcm_pkg::dp_status_t          status,
  input  logic [IDX_W-1:0]              rd_addr,
  input  logic [IDX_W-1:0]              wr_addr,
  input  logic [COORD_BITS-1:0]         box_left,
  input  logic [COORD_BITS-1:0]         box_top,
  input  logic [COORD_BITS-1:0]         box_width,
  input  logic [COORD_BITS-1:0]         box_height,
  input  logic [obcm_pkg::SCORE_W-1:0]  box_score,
  output logic                          out_valid,
  output logic [COORD_BITS-1:0]         out_left,
  output logic [COORD_BITS-1:0]         out_top,
  output logic [COORD_BITS:0]           out_width,
  output logic [COORD_BITS:0]           out_height,
  output logic [obcm_pkg::SCORE_W-1:0]  out_score,
  output logic                          is_last,
  output logic                          is_empty,
  output logic                          overflowed
);
  import obcm_pkg::*;

  localparam int CB    = COORD_BITS;
  localparam int EW    = COORD_BITS + 1;
  localparam int WORD_W = 2 * CB + 2 * EW + SCORE_W;

  // captured box, right and bottom as exclusive edges
  logic [CB-1:0]      b_left, b_top;
  logic [EW-1:0]      b_right, b_bottom;
  logic [SCORE_W-1:0] b_score;

  logic [WORD_W-1:0]  rd_data, wr_data;
  logic [CB-1:0]      c_left, c_top;
  logic [EW-1:0]      c_right, c_bottom;
  logic [SCORE_W-1:0] c_best;

  logic [CB-1:0]      i_left, i_top, u_left, u_top;
  logic [EW-1:0]      i_right, i_bottom, u_right, u_bottom;
  logic [SCORE_W-1:0] u_best;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      b_left   <= box_left;
      b_top    <= box_top;
      b_right  <= EW'(box_left) + EW'(box_width);
      b_bottom <= EW'(box_top) + EW'(box_height);
      b_score  <= box_score;
    end
  end

  obcm_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAX_CLUSTERS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (cmd.wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign {c_best, c_bottom, c_right, c_top, c_left} = rd_data;

  // intersection and union of the new box with the cluster just read
  always_comb begin
    i_left   = (b_left > c_left)     ? b_left   : c_left;
    i_top    = (b_top > c_top)       ? b_top    : c_top;
    i_right  = (b_right < c_right)   ? b_right  : c_right;
    i_bottom = (b_bottom < c_bottom) ? b_bottom : c_bottom;
    u_left   = (b_left < c_left)     ? b_left   : c_left;
    u_top    = (b_top < c_top)       ? b_top    : c_top;
    u_right  = (b_right > c_right)   ? b_right  : c_right;
    u_bottom = (b_bottom > c_bottom) ? b_bottom : c_bottom;
    u_best   = (b_score > c_best)    ? b_score  : c_best;
  end

  assign status.hit = (i_right > EW'(i_left)) && (i_bottom > EW'(i_top));

  assign wr_data = cmd.wr_merge ? {u_best, u_bottom, u_right, u_top, u_left}
                                : {b_score, b_bottom, b_right, b_top, b_left};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      is_last    <= cmd.last;
      is_empty   <= cmd.empty;
      overflowed <= cmd.ovf;
      if (cmd.empty) begin
        out_left   <= '0;
        out_top    <= '0;
        out_width  <= '0;
        out_height <= '0;
        out_score  <= '0;
      end else begin
        out_left   <= c_left;
        out_top    <= c_top;
        out_width  <= c_right - EW'(c_left);
        out_height <= c_bottom - EW'(c_top);
        out_score  <= c_best;
      end
    end
  end

endmodule

// ----- hdl/overlap_box_cluster_merge_top.sv -----
// Top level of the overlap box cluster merge block.
// Depends on obcm_pkg, obcm_ctrl, obcm_datapath and obcm_ram.
//
// Usage: drive opcode and the box fields with start high; the item is taken
// at a clock edge where start is high and busy is low. opcode add folds the
// box into the first stored cluster it overlaps, or appends it as a new
// cluster; when the table is full the box is dropped and the overflow flag
// set. opcode flush emits every cluster in insertion order on the out_*
// ports, one per cycle, each marked by out_valid for one cycle, is_last on
// the final one, then clears the table and the flag. A flush of an empty
// table gives one result with is_empty and is_last set.
// Timing: an add keeps busy high while it compares the box against the
// stored clusters (the cluster RAM is read one entry a cycle), up to
// MAX_CLUSTERS of them, or while it appends into an empty table. A flush
// keeps busy high while it emits its clusters; its results are shown one a
// cycle, the first from the clock edge after the accept edge on. An empty
// flush shows its result in the cycle right after the accept edge, with no busy.
// Results cannot be stalled: the receiver must take each when it is shown.
// Reset (rst, synchronous) empties the table and clears the flag; the RAM
// contents are not cleared since only written entries are read.
module overlap_box_cluster_merge_top #(
  parameter int MAX_CLUSTERS = 16,
  parameter int COORD_BITS   = 12
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          opcode,
  input  logic [COORD_BITS-1:0]         box_left,
  input  logic [COORD_BITS-1:0]         box_top,
  input  logic [COORD_BITS-1:0]         box_width,
  input  logic [COORD_BITS-1:0]         box_height,
  input  logic [obcm_pkg::SCORE_W-1:0]  box_score,
  output logic                          out_valid,
  output logic [COORD_BITS-1:0]         out_left,
  output logic [COORD_BITS-1:0]         out_top,
  output logic [COORD_BITS:0]           out_width,
  output logic [COORD_BITS:0]           out_height,
  output logic [obcm_pkg::SCORE_W-1:0]  out_score,
  output logic                          is_last,
  output logic                          is_empty,
  output logic                          overflowed
);
  import obcm_pkg::*;

  localparam int IDX_W = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;

  ctrl_cmd_t        cmd;
  dp_status_t       status;
  logic [IDX_W-1:0] rd_addr, wr_addr;

  obcm_ctrl #(
    .MAX_CLUSTERS (MAX_CLUSTERS)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .opcode  (opcode),
    .busy    (busy),
    .cmd     (cmd),
    .status  (status),
    .rd_addr (rd_addr),
    .wr_addr (wr_addr)
  );

  obcm_datapath #(
    .MAX_CLUSTERS (MAX_CLUSTERS),
    .COORD_BITS   (COORD_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .rd_addr    (rd_addr),
    .wr_addr    (wr_addr),
    .box_left   (box_left),
    .box_top    (box_top),
    .box_width  (box_width),
    .box_height (box_height),
    .box_score  (box_score),
    .out_valid  (out_valid),
    .out_left   (out_left),
    .out_top    (out_top),
    .out_width  (out_width),
    .out_height (out_height),
    .out_score  (out_score),
    .is_last    (is_last),
    .is_empty   (is_empty),
    .overflowed (overflowed)
  );

endmodule

// ----- sim/tb_overlap_box_cluster_merge_top.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for overlap_box_cluster_merge_top: adds and flushes boxes,
// predicts every flushed cluster and checks each result as it appears.
// Depends on obcm_pkg and the overlap_box_cluster_merge_top RTL.
module tb_overlap_box_cluster_merge_top;

  localparam int COORD_W      = 12;
  localparam int NUM_CLUSTERS = 16;
  localparam int RANDOM_ITEMS = 330;
  localparam int SETTLE       = 40;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int SHOW_MAX     = 10;

  typedef struct {
    logic               op;
    logic [COORD_W-1:0] left;
    logic [COORD_W-1:0] top;
    logic [COORD_W-1:0] width;
    logic [COORD_W-1:0] height;
    logic [15:0]        score;
  } box_t;

  typedef struct {
    logic [COORD_W-1:0] left;
    logic [COORD_W-1:0] top;
    logic [COORD_W:0]   width;
    logic [COORD_W:0]   height;
    logic [15:0]        score;
    logic               last;
    logic               empty;
    logic               ovf;
  } cluster_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic               opcode = obcm_pkg::OP_ADD;
  logic [COORD_W-1:0] box_left = '0;
  logic [COORD_W-1:0] box_top = '0;
  logic [COORD_W-1:0] box_width = '0;
  logic [COORD_W-1:0] box_height = '0;
  logic [15:0]        box_score = '0;
  logic               out_valid;
  logic [COORD_W-1:0] out_left;
  logic [COORD_W-1:0] out_top;
  logic [COORD_W:0]   out_width;
  logic [COORD_W:0]   out_height;
  logic [15:0]        out_score;
  logic               is_last;
  logic               is_empty;
  logic               overflowed;

  // Predicted cluster store, edges kept 13 bits wide and exclusive
  logic [COORD_W:0] tab_left   [NUM_CLUSTERS];
  logic [COORD_W:0] tab_top    [NUM_CLUSTERS];
  logic [COORD_W:0] tab_right  [NUM_CLUSTERS];
  logic [COORD_W:0] tab_bottom [NUM_CLUSTERS];
  logic [15:0]      tab_best   [NUM_CLUSTERS];
  int               n_clusters = 0;
  logic             drop_seen = 1'b0;

  cluster_t pending_clusters[$];
  int       fail_count = 0;
  int       mismatch_count = 0;
  int       cycles = 0;
  logic     steady = 1'b0;

  overlap_box_cluster_merge_top i_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .opcode     (opcode),
    .box_left   (box_left),
    .box_top    (box_top),
    .box_width  (box_width),
    .box_height (box_height),
    .box_score  (box_score),
    .out_valid  (out_valid),
    .out_left   (out_left),
    .out_top    (out_top),
    .out_width  (out_width),
    .out_height (out_height),
    .out_score  (out_score),
    .is_last    (is_last),
    .is_empty   (is_empty),
    .overflowed (overflowed)
  );

  always #2 clk = ~clk;

  function automatic box_t make_box(input logic op, input int l, input int t,
                                    input int w, input int h, input int s);
    box_t b;
    b.op     = op;
    b.left   = COORD_W'(l);
    b.top    = COORD_W'(t);
    b.width  = COORD_W'(w);
    b.height = COORD_W'(h);
    b.score  = 16'(s);
    return b;
  endfunction

  // Append one expected cluster at the tail of the queue
  function automatic void queue_result(input cluster_t c);
    pending_clusters.insert(pending_clusters.size(), c);
  endfunction

  // Fold one accepted item into the predicted store; a flush queues its clusters
  function automatic void merge_box(input box_t b);
    logic [COORD_W:0] l, t, r, bt, il, it, ir, ib;
    cluster_t c;
    if (b.op == obcm_pkg::OP_ADD) begin
      l  = {1'b0, b.left};
      t  = {1'b0, b.top};
      r  = l + {1'b0, b.width};
      bt = t + {1'b0, b.height};
      for (int k = 0; k < n_clusters; k++) begin
        il = (l > tab_left[k]) ? l : tab_left[k];
        it = (t > tab_top[k]) ? t : tab_top[k];
        ir = (r < tab_right[k]) ? r : tab_right[k];
        ib = (bt < tab_bottom[k]) ? bt : tab_bottom[k];
        if (ir > il && ib > it) begin
          if (l < tab_left[k]) tab_left[k] = l;
          if (t < tab_top[k]) tab_top[k] = t;
          if (r > tab_right[k]) tab_right[k] = r;
          if (bt > tab_bottom[k]) tab_bottom[k] = bt;
          if (b.score > tab_best[k]) tab_best[k] = b.score;
          return;
        end
      end
      if (n_clusters < NUM_CLUSTERS) begin
        tab_left[n_clusters]   = l;
        tab_top[n_clusters]    = t;
        tab_right[n_clusters]  = r;
        tab_bottom[n_clusters] = bt;
        tab_best[n_clusters]   = b.score;
        n_clusters++;
      end else begin
        drop_seen = 1'b1;
      end
    end else begin
      if (n_clusters == 0) begin
        c = '{default: '0};
        c.last  = 1'b1;
        c.empty = 1'b1;
        c.ovf   = drop_seen;
        queue_result(c);
      end
      for (int k = 0; k < n_clusters; k++) begin
        c.left   = tab_left[k][COORD_W-1:0];
        c.top    = tab_top[k][COORD_W-1:0];
        c.width  = tab_right[k] - tab_left[k];
        c.height = tab_bottom[k] - tab_top[k];
        c.score  = tab_best[k];
        c.last   = (k == n_clusters - 1);
        c.empty  = 1'b0;
        c.ovf    = drop_seen;
        queue_result(c);
      end
      n_clusters = 0;
      drop_seen  = 1'b0;
    end
  endfunction

  // Entered and left at a falling edge; hold start until the item is taken
  task automatic send_item(input box_t b);
    start      <= 1'b1;
    opcode     <= b.op;
    box_left   <= b.left;
    box_top    <= b.top;
    box_width  <= b.width;
    box_height <= b.height;
    box_score  <= b.score;
    @(posedge clk);
    while (busy) @(posedge clk);
    merge_box(b);
    @(negedge clk);
    if (!steady && $urandom_range(99) < 38) begin
      start <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < 38);
    end
  endtask

  // Hold off the sender until every queued cluster has come out
  task automatic wait_drained();
    if (pending_clusters.size() != 0) begin
      start <= 1'b0;
      while (pending_clusters.size() != 0) @(negedge clk);
    end
  endtask

  function automatic int pick_extent(input int max_ext);
    if ($urandom_range(99) < 5) return 0;
    return $urandom_range(1, max_ext);
  endfunction

  function automatic box_t rand_box(input logic op);
    return make_box(op, $urandom_range(0, 4095), $urandom_range(0, 4095),
                    $urandom_range(0, 4095), $urandom_range(0, 4095),
                    $urandom_range(0, 65535));
  endfunction

  task automatic test_empty_flush();
    send_item(make_box(obcm_pkg::OP_FLUSH, 0, 0, 0, 0, 0));
  endtask

  task automatic test_edge_boxes();
    send_item(make_box(obcm_pkg::OP_ADD, 0, 0, 0, 0, 'h0000));
    send_item(make_box(obcm_pkg::OP_ADD, 0, 0, 10, 10, 'h8000));
    // touches the right edge only: no overlap
    send_item(make_box(obcm_pkg::OP_ADD, 10, 0, 5, 5, 'h1234));
    // one pixel of overlap: merge
    send_item(make_box(obcm_pkg::OP_ADD, 9, 9, 1, 1, 'hFFFF));
    send_item(make_box(obcm_pkg::OP_ADD, 4095, 4095, 4095, 4095, 'hFFFF));
    send_item(make_box(obcm_pkg::OP_ADD, 4000, 4000, 200, 0, 'h0001));
    send_item(make_box(obcm_pkg::OP_ADD, 4000, 4000, 100, 100, 'h0002));
    send_item(make_box(obcm_pkg::OP_ADD, 2048, 2048, 1, 4095, 'h0001));
    send_item(make_box(obcm_pkg::OP_FLUSH, 4095, 4095, 4095, 4095, 'hFFFF));
  endtask

  task automatic test_table_full();
    for (int k = 0; k < NUM_CLUSTERS; k++)
      send_item(make_box(obcm_pkg::OP_ADD, 100 * k, 50, 60, 60, k));
    // no room: drop and raise the flag
    send_item(make_box(obcm_pkg::OP_ADD, 2000, 2000, 10, 10, 'h5555));
    // merging still works on a full store
    send_item(make_box(obcm_pkg::OP_ADD, 105, 55, 10, 10, 'hF0F0));
    wait_drained();
    send_item(make_box(obcm_pkg::OP_FLUSH, 0, 0, 0, 0, 0));
    send_item(make_box(obcm_pkg::OP_FLUSH, 0, 0, 0, 0, 0));
  endtask

  task automatic test_random_scenes();
    int sent, kind, nadd, bl, bt;
    sent   = 0;
    steady = 1'b1;
    while (sent < RANDOM_ITEMS) begin
      if (sent > 90) steady = 1'b0;
      kind = $urandom_range(99);
      bl   = $urandom_range(0, 3800);
      bt   = $urandom_range(0, 3800);
      if (kind < 60) nadd = $urandom_range(0, 24);
      else if (kind < 75) nadd = $urandom_range(14, 22);
      else if (kind < 90) nadd = $urandom_range(1, 20);
      else nadd = $urandom_range(1, 6);
      for (int k = 0; k < nadd; k++) begin
        if (kind < 60)
          // crowded scene: many overlaps and chains of merges
          send_item(make_box(obcm_pkg::OP_ADD, bl + $urandom_range(0, 250),
                             bt + $urandom_range(0, 250), pick_extent(96),
                             pick_extent(96), $urandom_range(0, 65535)));
        else if (kind < 75)
          // spread on a grid so the store can fill and overflow
          send_item(make_box(obcm_pkg::OP_ADD, (k % 8) * 500 + $urandom_range(0, 390),
                             (k / 8) * 1300 + $urandom_range(0, 1190), pick_extent(99),
                             pick_extent(99), $urandom_range(0, 65535)));
        else if (kind < 90)
          send_item(rand_box(obcm_pkg::OP_ADD));
        else
          send_item(rand_box(1'($urandom_range(0, 1))));
        sent++;
      end
      if ($urandom_range(9) == 0) wait_drained();
      send_item(rand_box(obcm_pkg::OP_FLUSH));
      sent++;
    end
  endtask

  always @(posedge clk) begin
    cluster_t e;
    if (!rst && out_valid) begin
      if (pending_clusters.size() == 0) begin
        fail_count++;
        mismatch_count++;
        if (mismatch_count <= SHOW_MAX)
          $display("unexpected cluster: left %0d top %0d w %0d h %0d score %0h",
                   out_left, out_top, out_width, out_height, out_score);
      end else begin
        e = pending_clusters.pop_front();
        if (out_left !== e.left || out_top !== e.top || out_width !== e.width ||
            out_height !== e.height || out_score !== e.score || is_last !== e.last ||
            is_empty !== e.empty || overflowed !== e.ovf) begin
          fail_count++;
          mismatch_count++;
          if (mismatch_count <= SHOW_MAX)
            $display("cluster mismatch: exp %0d %0d %0d %0d %0h l%0b e%0b o%0b,",
                     e.left, e.top, e.width, e.height, e.score, e.last, e.empty, e.ovf,
                     " got %0d %0d %0d %0d %0h l%0b e%0b o%0b",
                     out_left, out_top, out_width, out_height, out_score, is_last,
                     is_empty, overflowed);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("overlap_box_cluster_merge_top regression: fail");
      $finish;
    end
  end

  initial begin
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    test_empty_flush();
    test_edge_boxes();
    test_table_full();
    test_random_scenes();
    start <= 1'b0;
    while (pending_clusters.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (fail_count == 0 && pending_clusters.size() == 0) begin
      $display("overlap_box_cluster_merge_top regression: pass");
    end else begin
      $display("overlap_box_cluster_merge_top regression: fail");
    end
    $finish;
  end

endmodule
